>>> design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int CFG_W        = 5;
    localparam int IN_INDEX_W   = 4;
    localparam int IN_SIZE_W    = 16;
    localparam int OUT_NUM_W    = 4;
    localparam int OUT_SPACE_W  = 16;

    localparam logic [CFG_W-1:0] BLOCKS_RESET = 5'd16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_SKIP,
        CMD_ALLOC
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind              kind;
        logic [IN_INDEX_W-1:0]  index;
        logic [IN_SIZE_W-1:0]   size;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_head;

    typedef struct packed {
        logic                   granted;
        logic [OUT_NUM_W-1:0]   block_number;
        logic [OUT_SPACE_W-1:0] space_left;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } t_back_state;

endpackage

>>> design/ffba_if.sv
// ----------------------------------------------------------------------------
// ffba_if
// Request and response channels of the first-fit block allocator.
// ----------------------------------------------------------------------------
interface ffba_req_if
    import ffba_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [IN_INDEX_W-1:0] block_index;
    logic [IN_SIZE_W-1:0]  size;

    modport source (output valid, output op, output block_index, output size, input ready);
    modport sink   (input valid, input op, input block_index, input size, output ready);
endinterface

interface ffba_rsp_if
    import ffba_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   granted;
    logic [OUT_NUM_W-1:0]   block_number;
    logic [OUT_SPACE_W-1:0] space_left;

    modport source (output valid, output granted, output block_number, output space_left,
                    input ready);
    modport sink   (input valid, input granted, input block_number, input space_left,
                    output ready);
endinterface

>>> design/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a table of free space, one entry per memory block.
// ----------------------------------------------------------------------------
// usage
//   i_req carries items: op selects a load of one block size or an allocate
//   request. o_rsp returns one item for each request, in order.
//   i_cfg_we / i_cfg_wdata write blocks_in_use, the number of entries searched;
//   write it only while no item is in flight.
// throughput
//   the scan reads the table RAM through its single read port one entry per
//   cycle. a two-entry queue sits between the request side and the scan
//   engine, so up to two items are taken while the engine is busy.
// reset
//   clears the queue, the output register and all table entries (free space
//   zero) at once, and sets blocks_in_use to 16.
// stall
//   the result stays in the output register until taken; the engine then
//   waits, and the request side stops once the queue is full.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    ffba_req_if.sink         i_req,
    ffba_rsp_if.source       o_rsp
);

    logic [CFG_W-1:0] r_blocks_in_use;
    t_queue_head      head;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_in_use <= BLOCKS_RESET;
        end else if (i_cfg_we) begin
            r_blocks_in_use <= i_cfg_wdata;
        end
    end

    ffba_front #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_head  (head),
        .i_pop   (pop)
    );

    ffba_back #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_blocks_in_use (r_blocks_in_use),
        .i_head          (head),
        .o_pop           (pop),
        .o_rsp           (o_rsp)
    );

endmodule

>>> design/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/ffba_front.sv
// ----------------------------------------------------------------------------
// ffba_front
// Accepts request items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ffba_front
    import ffba_pkg::*;
#(
    parameter int NUM_BLOCKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffba_req_if.sink    i_req,
    output t_queue_head o_head,
    input  logic        i_pop
);

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       push;
    logic       pop;
    t_cmd       new_cmd;

    assign i_req.ready = (r_count != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign pop         = i_pop && (r_count != 2'd0);

    always_comb begin
        new_cmd.index = i_req.block_index;
        new_cmd.size  = i_req.size;
        if (i_req.op == OP_ALLOC) begin
            new_cmd.kind = CMD_ALLOC;
        end else if (32'(i_req.block_index) < NUM_BLOCKS) begin
            new_cmd.kind = CMD_LOAD;
        end else begin
            new_cmd.kind = CMD_SKIP;
        end
    end

    always_comb begin
        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= new_cmd;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.cmd   = r_q[r_rd_ptr];

endmodule

>>> design/ffba_back.sv
// ----------------------------------------------------------------------------
// ffba_back
// Executes queued items: table loads and the first-fit scan over the table.
// ----------------------------------------------------------------------------
module ffba_back
    import ffba_pkg::*;
#(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_blocks_in_use,
    input  t_queue_head      i_head,
    output logic             o_pop,
    ffba_rsp_if.source       o_rsp
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int PTR_W = $clog2(NUM_BLOCKS + 1);

    t_back_state           r_state;
    t_back_state           n_state;
    logic [SIZE_BITS-1:0]  r_size;
    logic [SIZE_BITS-1:0]  n_size;
    logic [PTR_W-1:0]      r_limit;
    logic [PTR_W-1:0]      n_limit;
    logic [PTR_W-1:0]      r_rd_ptr;
    logic [PTR_W-1:0]      n_rd_ptr;
    logic [PTR_W-1:0]      r_ev_ptr;
    logic [PTR_W-1:0]      n_ev_ptr;
    logic                  r_pend;
    logic                  n_pend;
    logic                  r_ev_vld;
    logic                  n_ev_vld;
    logic [NUM_BLOCKS-1:0] r_valid;
    t_result               r_res;
    t_result               n_res;
    logic                  r_out_valid;
    t_result               r_out;
    t_result               n_out;
    logic                  load_out;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [SIZE_BITS-1:0]  ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [SIZE_BITS-1:0]  ram_rdata;

    logic                  out_free;
    logic [PTR_W-1:0]      lim_eff;
    logic [SIZE_BITS-1:0]  head_size;
    logic [SIZE_BITS-1:0]  cur_space;
    logic [SIZE_BITS-1:0]  diff;
    logic                  fit;
    logic                  issue;

    ffba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free  = !r_out_valid || o_rsp.ready;
    assign lim_eff   = (32'(i_blocks_in_use) > NUM_BLOCKS) ? PTR_W'(NUM_BLOCKS)
                                                            : PTR_W'(i_blocks_in_use);
    assign head_size = SIZE_BITS'(i_head.cmd.size);
    assign cur_space = r_ev_vld ? ram_rdata : '0;
    assign diff      = cur_space - r_size;
    assign fit       = r_pend && (cur_space >= r_size);
    assign issue     = (r_rd_ptr < r_limit);
    assign ram_raddr = r_rd_ptr[IDX_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_size    = r_size;
        n_limit   = r_limit;
        n_rd_ptr  = r_rd_ptr;
        n_ev_ptr  = r_ev_ptr;
        n_pend    = r_pend;
        n_ev_vld  = r_ev_vld;
        n_res     = r_res;
        n_out     = r_out;
        load_out  = 1'b0;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    case (i_head.cmd.kind)
                        CMD_LOAD: begin
                            if (out_free) begin
                                o_pop     = 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = IDX_W'(i_head.cmd.index);
                                ram_wdata = head_size;
                                load_out  = 1'b1;
                                n_out     = '{granted: 1'b0, block_number: '0,
                                              space_left: OUT_SPACE_W'(head_size)};
                            end
                        end
                        CMD_SKIP: begin
                            if (out_free) begin
                                o_pop    = 1'b1;
                                load_out = 1'b1;
                                n_out    = '0;
                            end
                        end
                        CMD_ALLOC: begin
                            o_pop    = 1'b1;
                            n_size   = head_size;
                            n_limit  = lim_eff;
                            n_rd_ptr = '0;
                            n_pend   = 1'b0;
                            if (lim_eff == '0) begin
                                n_res   = '0;
                                n_state = ST_RESULT;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (fit) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_ev_ptr[IDX_W-1:0];
                    ram_wdata = diff;
                    n_pend    = 1'b0;
                    n_res     = '{granted: 1'b1, block_number: OUT_NUM_W'(r_ev_ptr),
                                  space_left: OUT_SPACE_W'(diff)};
                    n_state   = ST_RESULT;
                end else if (!issue) begin
                    n_pend  = 1'b0;
                    n_res   = '0;
                    n_state = ST_RESULT;
                end else begin
                    ram_re   = 1'b1;
                    n_rd_ptr = r_rd_ptr + PTR_W'(1);
                    n_ev_ptr = r_rd_ptr;
                    n_pend   = 1'b1;
                    n_ev_vld = r_valid[r_rd_ptr[IDX_W-1:0]];
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_out    = r_res;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_size   <= n_size;
        r_limit  <= n_limit;
        r_rd_ptr <= n_rd_ptr;
        r_ev_ptr <= n_ev_ptr;
        r_ev_vld <= n_ev_vld;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.granted      = r_out.granted;
    assign o_rsp.block_number = r_out.block_number;
    assign o_rsp.space_left   = r_out.space_left;

endmodule

>>> design/ffba_checker.sv
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks of the first-fit block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffba_checker
    import ffba_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_req_valid,
    input logic                   i_req_ready,
    input logic                   i_rsp_valid,
    input logic                   i_rsp_ready,
    input logic                   i_rsp_granted,
    input logic [OUT_NUM_W-1:0]   i_rsp_block_number
);

    logic [2:0] r_outstanding;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = i_req_valid && i_req_ready;
    assign rsp_acc = i_rsp_valid && i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= 3'd0;
        end else begin
            r_outstanding <= r_outstanding + 3'(req_acc) - 3'(rsp_acc);
        end
    end

    // queue, engine and output register hold four items at most
    a_outstanding_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= 3'd4)
        else $error("more items in flight than the block can hold");

    a_no_invented_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (r_outstanding != 3'd0))
        else $error("response item without an accepted request");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid && $stable(i_rsp_granted)
            && $stable(i_rsp_block_number))
        else $error("response dropped or changed while stalled");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_granted      (o_rsp.granted),
    .i_rsp_block_number (o_rsp.block_number)
);

>>> tb/first_fit_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb
// Drives load and allocate items into the first-fit allocator with random
// gaps and output stalls, predicts every result from a local copy of the
// free-space table and the search length, and checks results in order.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_tb;
    import ffba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BLOCKS     = 16;
    localparam int SIZE_BITS      = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic                  op;
        logic [IN_INDEX_W-1:0] block_index;
        logic [IN_SIZE_W-1:0]  size;
    } t_req_item;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    ffba_req_if req_bus ();
    ffba_rsp_if rsp_bus ();

    first_fit_block_allocator #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus)
    );

    t_req_item            req_pending [$];
    t_result              grant_expected [$];
    logic [IN_SIZE_W-1:0] free_space_model [NUM_BLOCKS];
    logic [CFG_W-1:0]     blocks_model;

    int unsigned mismatch_count;
    int unsigned idle_cycles;
    int unsigned req_gap;
    int unsigned rsp_stall;
    bit          req_idle_on;
    bit          rsp_idle_on;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_result first_fit_predict(input logic op,
                                                  input logic [IN_INDEX_W-1:0] idx,
                                                  input logic [IN_SIZE_W-1:0] sz);
        t_result r;
        int      span;
        r = '0;
        if (op == OP_LOAD) begin
            if (idx < NUM_BLOCKS) begin
                free_space_model[idx] = sz;
                r.space_left          = sz;
            end
            return r;
        end
        span = (blocks_model > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_model);
        for (int j = 0; j < span; j++) begin
            if (free_space_model[j] >= sz) begin
                free_space_model[j] = free_space_model[j] - sz;
                r.granted           = 1'b1;
                r.block_number      = OUT_NUM_W'(j);
                r.space_left        = free_space_model[j];
                return r;
            end
        end
        return r;
    endfunction

    function automatic int unsigned draw_wait(input bit enabled);
        return enabled ? $urandom_range(0, 9) : 0;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            req_gap       <= 0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                grant_expected.push_back(first_fit_predict(req_bus.op, req_bus.block_index,
                                                           req_bus.size));
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (req_gap != 0) begin
                    req_gap       <= req_gap - 1;
                    req_bus.valid <= 1'b0;
                end else if (req_pending.size() != 0) begin
                    t_req_item it;
                    it = req_pending.pop_front();
                    req_bus.op          <= it.op;
                    req_bus.block_index <= it.block_index;
                    req_bus.size        <= it.size;
                    req_bus.valid       <= 1'b1;
                    req_gap             <= draw_wait(req_idle_on);
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall     <= 0;
        end else if (rsp_bus.valid && rsp_bus.ready) begin
            t_result     got;
            t_result     want;
            int unsigned n;
            got.granted      = rsp_bus.granted;
            got.block_number = rsp_bus.block_number;
            got.space_left   = rsp_bus.space_left;
            if (grant_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: granted=%0d block=%0d space=%0d",
                             got.granted, got.block_number, got.space_left);
            end else begin
                want = grant_expected.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected granted=%0d block=%0d space=%0d,",
                                 want.granted, want.block_number, want.space_left,
                                 " got granted=%0d block=%0d space=%0d",
                                 got.granted, got.block_number, got.space_left);
                end
            end
            n = draw_wait(rsp_idle_on);
            rsp_stall     <= n;
            rsp_bus.ready <= (n == 0);
        end else if (rsp_stall != 0) begin
            rsp_stall     <= rsp_stall - 1;
            rsp_bus.ready <= (rsp_stall == 1);
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    // stall watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("first_fit_block_allocator_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_item(input logic op, input logic [IN_INDEX_W-1:0] idx,
                             input logic [IN_SIZE_W-1:0] sz);
        t_req_item it;
        it.op          = op;
        it.block_index = idx;
        it.size        = sz;
        req_pending.push_back(it);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (req_pending.size() != 0 || req_bus.valid || grant_expected.size() != 0);
    endtask

    task automatic set_blocks(input logic [CFG_W-1:0] value);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        blocks_model  = value;
        @(negedge i_clk);
    endtask

    function automatic logic [IN_SIZE_W-1:0] load_size();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return IN_SIZE_W'($urandom);
            default: return IN_SIZE_W'($urandom_range(1, 2000));
        endcase
    endfunction

    function automatic logic [IN_SIZE_W-1:0] alloc_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return IN_SIZE_W'($urandom);
            default: return IN_SIZE_W'($urandom_range(1, 400));
        endcase
    endfunction

    task automatic add_random_items(input int n_items);
        int added;
        int n_load;
        int n_alloc;
        int span;
        added = 0;
        span  = (blocks_model > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_model);
        while (added < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                // fill a few blocks, then allocate into them
                n_load  = $urandom_range(1, 4);
                n_alloc = $urandom_range(1, 6);
                for (int k = 0; k < n_load; k++) begin
                    if (span > 0 && $urandom_range(0, 3) != 0)
                        push_item(OP_LOAD, IN_INDEX_W'($urandom_range(0, span - 1)), load_size());
                    else
                        push_item(OP_LOAD, IN_INDEX_W'($urandom), load_size());
                end
                for (int k = 0; k < n_alloc; k++)
                    push_item(OP_ALLOC, IN_INDEX_W'($urandom), alloc_size());
                added += n_load + n_alloc;
            end else begin
                push_item(($urandom_range(0, 1) != 0) ? OP_ALLOC : OP_LOAD,
                          IN_INDEX_W'($urandom), IN_SIZE_W'($urandom));
                added++;
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] phase_blocks [9];
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        req_bus.valid       = 1'b0;
        req_bus.op          = OP_LOAD;
        req_bus.block_index = '0;
        req_bus.size        = '0;
        rsp_bus.ready       = 1'b0;
        mismatch_count      = 0;
        req_idle_on         = 1'b1;
        rsp_idle_on         = 1'b1;
        blocks_model        = BLOCKS_RESET;
        foreach (free_space_model[i]) free_space_model[i] = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table, zero request, whole-range sizes
        push_item(OP_ALLOC, 4'd0, 16'd0);
        push_item(OP_ALLOC, 4'd15, 16'd1);
        push_item(OP_ALLOC, 4'd0, 16'hFFFF);
        push_item(OP_LOAD, 4'd0, 16'hFFFF);
        push_item(OP_LOAD, 4'd15, 16'd1);
        push_item(OP_LOAD, 4'd5, 16'd100);
        push_item(OP_ALLOC, 4'd0, 16'hFFFF);
        push_item(OP_ALLOC, 4'd0, 16'd1);
        push_item(OP_ALLOC, 4'd0, 16'd99);
        push_item(OP_ALLOC, 4'd0, 16'd1);
        push_item(OP_ALLOC, 4'd0, 16'd1);
        push_item(OP_LOAD, 4'd15, 16'h8000);
        push_item(OP_LOAD, 4'd10, 16'h5555);
        push_item(OP_LOAD, 4'd11, 16'hAAAA);
        push_item(OP_ALLOC, 4'd10, 16'hAAAA);
        push_item(OP_ALLOC, 4'd5, 16'h5555);

        // search length zero
        set_blocks(5'd0);
        push_item(OP_ALLOC, 4'd0, 16'd0);
        push_item(OP_LOAD, 4'd3, 16'd50);
        push_item(OP_ALLOC, 4'd0, 16'd0);

        // search length above the table size
        set_blocks(5'd31);
        push_item(OP_ALLOC, 4'd0, 16'h8000);
        push_item(OP_ALLOC, 4'd0, 16'd0);
        set_blocks(5'd17);
        push_item(OP_LOAD, 4'd15, 16'd7);
        push_item(OP_ALLOC, 4'd0, 16'd7);

        // single entry searched
        set_blocks(5'd1);
        push_item(OP_ALLOC, 4'd0, 16'd1);
        push_item(OP_LOAD, 4'd0, 16'd10);
        push_item(OP_ALLOC, 4'd0, 16'd10);

        phase_blocks = '{5'd16, 5'd8, 5'd2, 5'd31, 5'd0, 5'd15, 5'd1, 5'd16, 5'd0};
        phase_blocks[8] = CFG_W'($urandom_range(3, 14));
        for (int ph = 0; ph < 9; ph++) begin
            set_blocks(phase_blocks[ph]);
            req_idle_on = (ph % 3 != 2);
            rsp_idle_on = (ph % 4 != 1);
            add_random_items(56);
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (grant_expected.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0) begin
            $display("first_fit_block_allocator_tb passed");
        end else begin
            $display("first_fit_block_allocator_tb failed");
        end
        $finish;
    end

endmodule

>>> sim.f
design/ffba_pkg.sv
design/ffba_if.sv
design/ffba_ram.sv
design/ffba_front.sv
design/ffba_back.sv
design/first_fit_block_allocator.sv
design/ffba_checker.sv
tb/first_fit_block_allocator_tb.sv
